// File: hdl/dmw_pkg.sv
// Shared types, constants and the 5x7 font for the two-digit dot-matrix writer.
// No dependencies; imported by every module of the block.
package dmw_pkg;

	localparam int GLYPH_ROWS    = 7;
	localparam int GLYPH_COLUMNS = 5;

	localparam int VALUE_W = 7;
	localparam int GLYPH_W = 4;
	localparam int ROW_W   = 3;
	localparam int SEQ_W   = $clog2(2 * GLYPH_ROWS + 2);

	localparam logic [VALUE_W-1:0] PLAY_VALUE      = 7'd100;
	localparam logic [VALUE_W-1:0] SATURATED_VALUE = 7'd99;
	localparam logic [VALUE_W-1:0] TWO_DIGIT_MIN   = 7'd10;
	localparam logic [GLYPH_W-1:0] PLAY_GLYPH      = 4'd10;

	localparam logic [7:0] BLANK_COLUMNS = 8'hFF;
	localparam logic [6:0] BLANK_ROWS    = 7'd0;
	localparam logic [7:0] COL_MASK      = 8'((1 << GLYPH_COLUMNS) - 1);

	localparam logic DISP_LEFT  = 1'b0;
	localparam logic DISP_RIGHT = 1'b1;

	// Write index codes for the two blanking writes; glyph rows follow.
	localparam logic [SEQ_W-1:0] IDX_BLANK_LEFT  = SEQ_W'(0);
	localparam logic [SEQ_W-1:0] IDX_BLANK_RIGHT = SEQ_W'(1);
	localparam logic [SEQ_W-1:0] IDX_GLYPH0      = SEQ_W'(2);
	localparam logic [SEQ_W-1:0] IDX_LAST_ONE    = SEQ_W'(GLYPH_ROWS + 1);
	localparam logic [SEQ_W-1:0] IDX_LAST_TWO    = SEQ_W'(2 * GLYPH_ROWS + 1);

	// Bit k is column k from the left, 1 means lit.
	localparam logic [7:0] GLYPH_FONT [11][8] = '{
		'{8'h0E, 8'h11, 8'h13, 8'h15, 8'h19, 8'h11, 8'h0E, 8'h00},
		'{8'h04, 8'h06, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0E, 8'h00},
		'{8'h0F, 8'h10, 8'h08, 8'h04, 8'h06, 8'h01, 8'h1E, 8'h00},
		'{8'h0F, 8'h10, 8'h10, 8'h0E, 8'h10, 8'h10, 8'h0F, 8'h00},
		'{8'h04, 8'h06, 8'h05, 8'h05, 8'h1F, 8'h04, 8'h04, 8'h00},
		'{8'h1E, 8'h01, 8'h01, 8'h1F, 8'h10, 8'h10, 8'h0F, 8'h00},
		'{8'h0E, 8'h01, 8'h01, 8'h0F, 8'h11, 8'h11, 8'h0E, 8'h00},
		'{8'h1F, 8'h10, 8'h10, 8'h0C, 8'h04, 8'h04, 8'h04, 8'h00},
		'{8'h0E, 8'h11, 8'h11, 8'h0E, 8'h11, 8'h11, 8'h0E, 8'h00},
		'{8'h0E, 8'h11, 8'h11, 8'h1E, 8'h10, 8'h10, 8'h0F, 8'h00},
		'{8'h01, 8'h03, 8'h0F, 8'h1F, 8'h0F, 8'h03, 8'h01, 8'h00}
	};

	typedef struct packed {
		logic [GLYPH_W-1:0] glyph_first;
		logic [GLYPH_W-1:0] glyph_second;
		logic               two_glyphs;
	} item_t;

	typedef struct packed {
		logic       display_select;
		logic [6:0] row_select;
		logic [7:0] column_pattern;
		logic       last_write;
	} write_t;

	function automatic logic [7:0] glyph_row(input logic [GLYPH_W-1:0] g,
		input logic [ROW_W-1:0] r);
		logic [GLYPH_W-1:0] gs;
		gs = (g > PLAY_GLYPH) ? PLAY_GLYPH : g;
		return GLYPH_FONT[gs][r];
	endfunction

	// Saturate, then split into glyph codes. tens = (v * 205) >> 11 is exact for v <= 99.
	function automatic item_t split_value(input logic [VALUE_W-1:0] v_in);
		logic [VALUE_W-1:0] v;
		logic [14:0]        prod;
		logic [GLYPH_W-1:0] tens;
		logic [GLYPH_W-1:0] units;
		item_t              it;
		v     = (v_in > PLAY_VALUE) ? SATURATED_VALUE : v_in;
		prod  = 15'(v) * 15'd205;
		tens  = prod[14:11];
		units = GLYPH_W'(v - VALUE_W'(tens) * VALUE_W'(10));
		if (v == PLAY_VALUE) begin
			it.glyph_first  = PLAY_GLYPH;
			it.glyph_second = PLAY_GLYPH;
			it.two_glyphs   = 1'b1;
		end else if (v >= TWO_DIGIT_MIN) begin
			it.glyph_first  = tens;
			it.glyph_second = units;
			it.two_glyphs   = 1'b1;
		end else begin
			it.glyph_first  = units;
			it.glyph_second = units;
			it.two_glyphs   = 1'b0;
		end
		return it;
	endfunction

endpackage

// File: hdl/dmw_write_gen.sv
// Builds one display register write from the held item and the write index.
// Depends on dmw_pkg (font, item and write types).
module dmw_write_gen import dmw_pkg::*; (
	input  item_t            item,
	input  logic [SEQ_W-1:0] idx,
	output write_t           wr
);

	logic [SEQ_W-1:0]   j;
	logic               second;
	logic [SEQ_W-1:0]   row_full;
	logic [ROW_W-1:0]   row;
	logic [GLYPH_W-1:0] glyph;
	logic [7:0]         lit;

	assign j        = idx - IDX_GLYPH0;
	assign second   = (j >= SEQ_W'(GLYPH_ROWS));
	// rows go out bottom row first
	assign row_full = second ? SEQ_W'(2 * GLYPH_ROWS - 1) - j : SEQ_W'(GLYPH_ROWS - 1) - j;
	assign row      = row_full[ROW_W-1:0];
	assign glyph    = second ? item.glyph_second : item.glyph_first;
	assign lit      = glyph_row(glyph, row) & COL_MASK;

	always_comb begin
		wr.last_write = item.two_glyphs ? (idx == IDX_LAST_TWO) : (idx == IDX_LAST_ONE);
		case (idx)
			IDX_BLANK_LEFT: begin
				wr.display_select = DISP_LEFT;
				wr.row_select     = BLANK_ROWS;
				wr.column_pattern = BLANK_COLUMNS;
			end
			IDX_BLANK_RIGHT: begin
				wr.display_select = DISP_RIGHT;
				wr.row_select     = BLANK_ROWS;
				wr.column_pattern = BLANK_COLUMNS;
			end
			default: begin
				// a lone digit goes to the right display
				wr.display_select = item.two_glyphs ? second : DISP_RIGHT;
				wr.row_select     = 7'(8'd1 << row);
				wr.column_pattern = ~lit;
			end
		endcase
	end

endmodule

// File: hdl/dot_matrix_two_digit_writer.sv
// Two-digit writer for a pair of 5x7 dot-matrix displays: top level.
// Depends on dmw_pkg and dmw_write_gen.
//
// Input channel (in_valid/in_ready, shown_value): one number per transfer.
// 0..9 draws on the right display, 10..99 tens left and units right,
// 100 a play icon on both; 101..127 shows 99.
// Output channel (out_valid/out_ready): one row-register write per transfer.
// Every number first blanks left then right (row_select 0, columns 0xFF),
// then sends each glyph from the bottom row up; last_write marks the end.
// A number yields 2 + GLYPH_ROWS writes (one digit) or 2 + 2*GLYPH_ROWS.
// The number is held in the sequencer (item_s1, idx_s1) and each write
// is registered in out_q. Throughput: one write per cycle while the
// receiver does not stall. The next number is taken in the cycle its
// predecessor's last write enters the output register, so writes stream
// with no gap.
// When the receiver stalls, the output register holds and the sequencer
// waits; in_ready stays low until the last write can move.
// Reset (arst_n low) drops any number in progress and clears out_valid.
module dot_matrix_two_digit_writer import dmw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] shown_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               display_select,
	output logic [6:0]         row_select,
	output logic [7:0]         column_pattern,
	output logic               last_write
);

	item_t            item_s1;
	logic [SEQ_W-1:0] idx_s1;
	logic             busy_s1;
	logic             out_valid_q;
	write_t           out_q;
	write_t           wr;
	logic             adv;
	logic             in_xfer;

	assign adv      = busy_s1 && (!out_valid_q || out_ready);
	assign in_ready = !busy_s1 || (adv && wr.last_write);
	assign in_xfer  = in_valid && in_ready;

	dmw_write_gen u_gen (
		.item (item_s1),
		.idx  (idx_s1),
		.wr   (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			idx_s1  <= '0;
		end else if (in_xfer) begin
			busy_s1 <= 1'b1;
			idx_s1  <= IDX_BLANK_LEFT;
		end else if (adv) begin
			idx_s1 <= idx_s1 + SEQ_W'(1);
			if (wr.last_write) begin
				busy_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= split_value(shown_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= wr;
		end
	end

	assign out_valid      = out_valid_q;
	assign display_select = out_q.display_select;
	assign row_select     = out_q.row_select;
	assign column_pattern = out_q.column_pattern;
	assign last_write     = out_q.last_write;

endmodule

// File: hdl/dmw_checker.sv
// Port-level checks for the two-digit dot-matrix writer, bound to the top level.
// Depends on dmw_pkg and dot_matrix_two_digit_writer.
module dmw_checker import dmw_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               display_select,
	input logic [6:0]         row_select,
	input logic [7:0]         column_pattern,
	input logic               last_write
);

	// stalled write holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(display_select)
		&& $stable(row_select) && $stable(column_pattern) && $stable(last_write))
		else $error("stalled write changed");

	a_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(row_select))
		else $error("row_select not one-hot");

	// rows with no select bit are blanking writes: all columns off
	a_blank_cols: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_select == BLANK_ROWS |-> column_pattern == BLANK_COLUMNS)
		else $error("blank write with lit columns");

	// every sequence ends on the right display
	a_last_right: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_write |-> display_select == DISP_RIGHT)
		else $error("last write not on right display");

endmodule

bind dot_matrix_two_digit_writer dmw_checker u_dmw_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for dot_matrix_two_digit_writer: numbers in, row writes out.
// Depends on dmw_pkg (port widths, display codes) and the block's RTL.
module testbench;
	import dmw_pkg::*;

	localparam int RANDOM_ITEMS = 108;
	localparam int IDLE_PCT     = 23;
	localparam int HOLD_AT      = 60;   // receiver hold-off starts after this many transfers
	localparam int HOLD_CYCLES  = 120;
	localparam int STEADY_FROM  = 85;   // no idling on either side in this window
	localparam int STEADY_TO    = 115;
	localparam int DRAIN_CYCLES = 40;

	// Lit pixels per glyph row, bit k = column k from the left; glyph 10 is the play icon.
	localparam logic [7:0] LIT_ROWS [11][8] = '{
		'{8'h0E, 8'h11, 8'h13, 8'h15, 8'h19, 8'h11, 8'h0E, 8'h00},
		'{8'h04, 8'h06, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0E, 8'h00},
		'{8'h0F, 8'h10, 8'h08, 8'h04, 8'h06, 8'h01, 8'h1E, 8'h00},
		'{8'h0F, 8'h10, 8'h10, 8'h0E, 8'h10, 8'h10, 8'h0F, 8'h00},
		'{8'h04, 8'h06, 8'h05, 8'h05, 8'h1F, 8'h04, 8'h04, 8'h00},
		'{8'h1E, 8'h01, 8'h01, 8'h1F, 8'h10, 8'h10, 8'h0F, 8'h00},
		'{8'h0E, 8'h01, 8'h01, 8'h0F, 8'h11, 8'h11, 8'h0E, 8'h00},
		'{8'h1F, 8'h10, 8'h10, 8'h0C, 8'h04, 8'h04, 8'h04, 8'h00},
		'{8'h0E, 8'h11, 8'h11, 8'h0E, 8'h11, 8'h11, 8'h0E, 8'h00},
		'{8'h0E, 8'h11, 8'h11, 8'h1E, 8'h10, 8'h10, 8'h0F, 8'h00},
		'{8'h01, 8'h03, 8'h0F, 8'h1F, 8'h0F, 8'h03, 8'h01, 8'h00}
	};

	// Every digit, both digit-count boundaries, play, saturation, all-ones and single bits 1, 2, 4, 8 and 64.
	localparam logic [VALUE_W-1:0] DIRECTED [22] = '{
		7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10,
		7'd19, 7'd42, 7'd57, 7'd63, 7'd64, 7'd99, 7'd100, 7'd101, 7'd126, 7'd127, 7'd85
	};

	class row_write_board;
		write_t pending_writes[$];
		int     errors;

		function void push_write(logic disp, logic [6:0] rows, logic [7:0] cols);
			write_t w;
			w.display_select = disp;
			w.row_select     = rows;
			w.column_pattern = cols;
			w.last_write     = 1'b0;
			pending_writes.push_back(w);
		endfunction

		// Bottom row first; row_select is one-hot and columns are active low.
		function void push_glyph(logic disp, int glyph);
			logic [7:0] lit;
			for (int r = GLYPH_ROWS - 1; r >= 0; r--) begin
				lit = LIT_ROWS[glyph][r & 7] & COL_MASK;
				push_write(disp, 7'((8'd1 << (r & 7)) & 8'h7F), ~lit);
			end
		endfunction

		function void note_value(logic [VALUE_W-1:0] raw);
			logic [VALUE_W-1:0] v;
			v = (raw > PLAY_VALUE) ? SATURATED_VALUE : raw;
			push_write(DISP_LEFT, BLANK_ROWS, BLANK_COLUMNS);
			push_write(DISP_RIGHT, BLANK_ROWS, BLANK_COLUMNS);
			if (v == PLAY_VALUE) begin
				push_glyph(DISP_LEFT, PLAY_GLYPH);
				push_glyph(DISP_RIGHT, PLAY_GLYPH);
			end else if (v >= TWO_DIGIT_MIN) begin
				push_glyph(DISP_LEFT, v / 10);
				push_glyph(DISP_RIGHT, v % 10);
			end else begin
				push_glyph(DISP_RIGHT, v);
			end
			pending_writes[pending_writes.size() - 1].last_write = 1'b1;
		endfunction

		function void check_write(write_t got);
			write_t exp_w;
			if (pending_writes.size() == 0) begin
				$error("write with none pending: disp %0d rows %h cols %h last %0d",
					got.display_select, got.row_select, got.column_pattern, got.last_write);
				errors++;
				return;
			end
			exp_w = pending_writes.pop_front();
			if (got.display_select !== exp_w.display_select) begin
				$error("display_select: expected %0d, got %0d",
					exp_w.display_select, got.display_select);
				errors++;
			end
			if (got.row_select !== exp_w.row_select) begin
				$error("row_select: expected %h, got %h", exp_w.row_select, got.row_select);
				errors++;
			end
			if (got.column_pattern !== exp_w.column_pattern) begin
				$error("column_pattern: expected %h, got %h",
					exp_w.column_pattern, got.column_pattern);
				errors++;
			end
			if (got.last_write !== exp_w.last_write) begin
				$error("last_write: expected %0d, got %0d", exp_w.last_write, got.last_write);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [VALUE_W-1:0] shown_value;
	logic               out_valid;
	logic               out_ready;
	logic               display_select;
	logic [6:0]         row_select;
	logic [7:0]         column_pattern;
	logic               last_write;

	row_write_board board;
	write_t         seen_write;
	int             sent_count;
	bit             hold_done;

	dot_matrix_two_digit_writer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.shown_value    (shown_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.display_select (display_select),
		.row_select     (row_select),
		.column_pattern (column_pattern),
		.last_write     (last_write)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit steady_window();
		return sent_count >= STEADY_FROM && sent_count < STEADY_TO;
	endfunction

	// Inputs only change at rising edges, so the negedge sees what the next edge accepts.
	task automatic send_value(input logic [VALUE_W-1:0] v);
		while (!steady_window() && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid    <= 1'b0;
			shown_value <= VALUE_W'($urandom);
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		shown_value <= v;
		do @(negedge clk); while (!in_ready);
		board.note_value(v);
		sent_count++;
		@(posedge clk);
	endtask

	initial begin : receiver
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sent_count >= HOLD_AT) begin
				// long hold-off so the output side backs up into in_ready
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			if (steady_window())
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_write.display_select = display_select;
			seen_write.row_select     = row_select;
			seen_write.column_pattern = column_pattern;
			seen_write.last_write     = last_write;
			board.check_write(seen_write);
		end
	end

	initial begin : stimulus
		board       = new();
		sent_count  = 0;
		hold_done   = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		shown_value = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_value(DIRECTED[i]);
		// mostly legal numbers, with a share of out-of-range values
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 80)
				send_value(VALUE_W'($urandom_range(0, 100)));
			else
				send_value(VALUE_W'($urandom_range(0, 127)));
		end
		in_valid <= 1'b0;

		while (board.pending_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
hdl/dmw_pkg.sv
hdl/dmw_write_gen.sv
hdl/dot_matrix_two_digit_writer.sv
hdl/dmw_checker.sv
sim/testbench.sv
